[rtl/assert_macros.svh]
// Assertion macros shared by the sorted priority queue modules.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SPQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg)
`define SPQ_ASSERT_SAME(lbl, ante, cons, msg)
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/spq_pkg.sv]
// Package for the sorted priority queue: field widths, codes and word types.
// Used by spq_ctrl, spq_dpath and sorted_priority_queue; depends on nothing.
`default_nettype none
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PRIO_W      = 8;
  localparam int TAG_W       = 16;
  localparam int OCC_W       = 5;
  localparam int STATUS_W    = 2;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic              action;
    logic [PRIO_W-1:0] entry_priority;
    logic [TAG_W-1:0]  entry_tag;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PRIO_W-1:0]   removed_priority;
    logic [TAG_W-1:0]    removed_tag;
    logic                head_valid;
    logic [PRIO_W-1:0]   head_priority;
    logic [TAG_W-1:0]    head_tag;
    logic [OCC_W-1:0]    occupancy;
  } out_word_t;

  typedef enum logic {
    CTL_IDLE,
    CTL_EXEC
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } spq_cmd_t;

endpackage
`default_nettype wire

[rtl/sorted_priority_queue.sv]
// Sorted priority queue, highest priority at the head and arrival order kept
// among equal priorities. Each accepted word is a push or a pop and yields one
// result word: the load step puts it in the request register and the execute
// step writes the result register, waiting while that one is still held. No new
// word is taken before that execute step, in which all slots of the sorted register
// chain compare and shift in parallel. A new word is taken while a result waits.
// Depends on spq_pkg, spq_ctrl and spq_dpath.
`default_nettype none
module sorted_priority_queue #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire spq_pkg::in_word_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output spq_pkg::out_word_t     out_data
);

  spq_pkg::spq_cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  spq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

[rtl/spq_dpath.sv]
// Datapath of the sorted priority queue: request register, sorted slot chain,
// entry count and result register. Depends on spq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module spq_dpath #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire spq_pkg::spq_cmd_t cmd,
  input  wire spq_pkg::in_word_t in_data,
  output spq_pkg::out_word_t     out_data
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  spq_pkg::in_word_t             req_r;
  spq_pkg::out_word_t            res_r;
  spq_pkg::out_word_t            res_nxt;
  logic [spq_pkg::PRIO_W-1:0]    prio_r   [QUEUE_DEPTH];
  logic [spq_pkg::TAG_W-1:0]     tag_r    [QUEUE_DEPTH];
  logic [spq_pkg::PRIO_W-1:0]    prio_nxt [QUEUE_DEPTH];
  logic [spq_pkg::TAG_W-1:0]     tag_nxt  [QUEUE_DEPTH];
  logic [spq_pkg::PRIO_W-1:0]    dn_prio  [QUEUE_DEPTH];
  logic [spq_pkg::TAG_W-1:0]     dn_tag   [QUEUE_DEPTH];
  logic [spq_pkg::PRIO_W-1:0]    up_prio  [QUEUE_DEPTH];
  logic [spq_pkg::TAG_W-1:0]     up_tag   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]        ge;
  logic [QUEUE_DEPTH-1:0]        prev_ge;
  logic [CNT_W-1:0]              count_r;
  logic [CNT_W-1:0]              count_nxt;
  logic                          full;
  logic                          empty;
  logic                          do_push;
  logic                          do_pop;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = (req_r.action == spq_pkg::ACT_PUSH) && !full;
  assign do_pop  = (req_r.action == spq_pkg::ACT_POP) && !empty;

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ge[i] = (CNT_W'(i) < count_r) && (prio_r[i] >= req_r.entry_priority);
    end
    prev_ge = {ge[QUEUE_DEPTH-2:0], 1'b1};
  end

  always_comb begin
    dn_prio[0] = req_r.entry_priority;
    dn_tag[0]  = req_r.entry_tag;
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      dn_prio[i] = prio_r[i-1];
      dn_tag[i]  = tag_r[i-1];
    end
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      up_prio[i] = prio_r[i+1];
      up_tag[i]  = tag_r[i+1];
    end
    up_prio[QUEUE_DEPTH-1] = prio_r[QUEUE_DEPTH-1];
    up_tag[QUEUE_DEPTH-1]  = tag_r[QUEUE_DEPTH-1];
  end

  // A pushed entry lands in the first slot whose own entry is not kept in place.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      prio_nxt[i] = prio_r[i];
      tag_nxt[i]  = tag_r[i];
      if (do_push && !ge[i]) begin
        if (prev_ge[i]) begin
          prio_nxt[i] = req_r.entry_priority;
          tag_nxt[i]  = req_r.entry_tag;
        end else begin
          prio_nxt[i] = dn_prio[i];
          tag_nxt[i]  = dn_tag[i];
        end
      end else if (do_pop) begin
        prio_nxt[i] = up_prio[i];
        tag_nxt[i]  = up_tag[i];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (do_push) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_comb begin
    res_nxt = '0;
    if ((req_r.action == spq_pkg::ACT_PUSH) && full) begin
      res_nxt.status = spq_pkg::STATUS_FULL;
    end else if ((req_r.action == spq_pkg::ACT_POP) && empty) begin
      res_nxt.status = spq_pkg::STATUS_EMPTY;
    end else begin
      res_nxt.status = spq_pkg::STATUS_DONE;
    end
    if (do_pop) begin
      res_nxt.removed_priority = prio_r[0];
      res_nxt.removed_tag      = tag_r[0];
    end
    if (count_nxt != '0) begin
      res_nxt.head_valid    = 1'b1;
      res_nxt.head_priority = prio_nxt[0];
      res_nxt.head_tag      = tag_nxt[0];
    end
    res_nxt.occupancy = spq_pkg::OCC_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (cmd.exec) begin
      res_r <= res_nxt;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        prio_r[i] <= prio_nxt[i];
        tag_r[i]  <= tag_nxt[i];
      end
    end
  end

  assign out_data = res_r;

  `SPQ_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(QUEUE_DEPTH), "Count exceeds depth.")
  `SPQ_ASSERT_NEXT(a_push_grows, cmd.exec && do_push, count_r == $past(count_r) + 1'b1, "Push lost.")
  `SPQ_ASSERT_NEXT(a_reject_holds, cmd.exec && !do_push && !do_pop, $stable(count_r), "Count moved.")
  `SPQ_ASSERT_SAME(a_head_sorted, count_r >= CNT_W'(2), prio_r[0] >= prio_r[1], "Head unsorted.")

endmodule
`default_nettype wire

[rtl/spq_ctrl.sv]
// Controller of the sorted priority queue: load and execute sequencing and the
// result valid flag. Depends on spq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module spq_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  output spq_pkg::spq_cmd_t cmd
);

  spq_pkg::ctl_state_t state_r;
  spq_pkg::ctl_state_t state_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spq_pkg::CTL_IDLE: begin
        if (in_valid) begin
          state_nxt = spq_pkg::CTL_EXEC;
        end
      end
      spq_pkg::CTL_EXEC: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = spq_pkg::CTL_IDLE;
        end
      end
      default: begin
        state_nxt = spq_pkg::CTL_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      spq_pkg::CTL_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      spq_pkg::CTL_EXEC: begin
        cmd.exec = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spq_pkg::CTL_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `SPQ_ASSERT_NEXT(a_load_then_exec, cmd.load, state_r == spq_pkg::CTL_EXEC, "No execute after load.")
  `SPQ_ASSERT_NEXT(a_exec_shows, cmd.exec, out_valid_r && state_r == spq_pkg::CTL_IDLE, "Result not shown.")
  `SPQ_ASSERT_NEXT(a_stall_waits, state_r == spq_pkg::CTL_EXEC && out_valid_r && !out_ready, state_r == spq_pkg::CTL_EXEC, "Result overwritten.")

endmodule
`default_nettype wire

[tb/tb_sorted_priority_queue.sv]
// Self-checking testbench for sorted_priority_queue: directed and random push and pop
// words, checked against a sorted-queue predictor kept alongside. Depends on spq_pkg and
// the sorted_priority_queue RTL.
module tb_sorted_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_WORDS = 1600;
  localparam int TAIL_CYCLES  = 10;

  typedef struct {
    spq_pkg::in_word_t word;
    bit                drain_first;
  } pending_word_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  spq_pkg::in_word_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  spq_pkg::out_word_t out_data;

  pending_word_t      pending_words[$];
  spq_pkg::out_word_t awaited_results[$];

  logic [spq_pkg::PRIO_W-1:0] model_prio[spq_pkg::QUEUE_DEPTH];
  logic [spq_pkg::TAG_W-1:0]  model_tag[spq_pkg::QUEUE_DEPTH];
  int                         model_count = 0;

  int mismatches = 0;
  int idle_cycles = 0;
  int burst_left = 1;
  int gap_left = 0;
  int ready_mode = 0;
  int ready_phase = 0;

  sorted_priority_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic spq_pkg::out_word_t next_result(spq_pkg::in_word_t w);
    spq_pkg::out_word_t r;
    int pos;
    r = '0;
    if (w.action == spq_pkg::ACT_PUSH) begin
      if (model_count >= spq_pkg::QUEUE_DEPTH) begin
        r.status = spq_pkg::STATUS_FULL;
      end else begin
        pos = 0;
        while (pos < model_count && model_prio[pos] >= w.entry_priority) pos++;
        for (int i = model_count; i > pos; i--) begin
          model_prio[i] = model_prio[i-1];
          model_tag[i]  = model_tag[i-1];
        end
        model_prio[pos] = w.entry_priority;
        model_tag[pos]  = w.entry_tag;
        model_count++;
        r.status = spq_pkg::STATUS_DONE;
      end
    end else begin
      if (model_count == 0) begin
        r.status = spq_pkg::STATUS_EMPTY;
      end else begin
        r.status           = spq_pkg::STATUS_DONE;
        r.removed_priority = model_prio[0];
        r.removed_tag      = model_tag[0];
        for (int i = 1; i < model_count; i++) begin
          model_prio[i-1] = model_prio[i];
          model_tag[i-1]  = model_tag[i];
        end
        model_count--;
      end
    end
    if (model_count > 0) begin
      r.head_valid    = 1'b1;
      r.head_priority = model_prio[0];
      r.head_tag      = model_tag[0];
    end
    r.occupancy = model_count[spq_pkg::OCC_W-1:0];
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s expected %0h, got %0h", $realtime, name, want, got);
    end
  endtask

  task automatic add_push(int prio, int tag, bit drain);
    pending_word_t p;
    p.word.action         = spq_pkg::ACT_PUSH;
    p.word.entry_priority = prio[spq_pkg::PRIO_W-1:0];
    p.word.entry_tag      = tag[spq_pkg::TAG_W-1:0];
    p.drain_first         = drain;
    pending_words.push_back(p);
  endtask

  task automatic add_pop(bit drain);
    pending_word_t p;
    p.word.action         = spq_pkg::ACT_POP;
    p.word.entry_priority = spq_pkg::PRIO_W'($urandom_range(0, 255));
    p.word.entry_tag      = spq_pkg::TAG_W'($urandom_range(0, 65535));
    p.drain_first         = drain;
    pending_words.push_back(p);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        awaited_results.push_back(next_result(in_data));
      end
      if (in_valid && !in_ready) begin
        in_valid <= 1'b1;
      end else if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (pending_words.size() != 0 &&
                   !(pending_words[0].drain_first && awaited_results.size() != 0)) begin
        in_data  <= pending_words[0].word;
        in_valid <= 1'b1;
        pending_words.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (ready_phase == 0) begin
      ready_mode  = $urandom_range(0, 3);
      ready_phase = $urandom_range(20, 80);
    end else begin
      ready_phase--;
    end
    case (ready_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_ready <= (ready_phase % 4 == 0);
      end
      default: begin
        out_ready <= ($urandom_range(0, 7) != 0);
      end
    endcase
  end

  always @(posedge clk) begin : result_check
    spq_pkg::out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result word %0h", $realtime, out_data);
      end else begin
        want = awaited_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_data.status));
        check_field("removed_priority", 32'(want.removed_priority),
                    32'(out_data.removed_priority));
        check_field("removed_tag", 32'(want.removed_tag), 32'(out_data.removed_tag));
        check_field("head_valid", 32'(want.head_valid), 32'(out_data.head_valid));
        check_field("head_priority", 32'(want.head_priority), 32'(out_data.head_priority));
        check_field("head_tag", 32'(want.head_tag), 32'(out_data.head_tag));
        check_field("occupancy", 32'(want.occupancy), 32'(out_data.occupancy));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int issued;
    int mode;
    int len;
    int push_pct;
    bit narrow;
    bit timed_out;

    // Directed part: empty pop, field extremes, equal priorities, fill past full.
    add_pop(1'b0);
    add_push(0, 16'h0000, 1'b0);
    add_push(255, 16'hffff, 1'b0);
    add_push(128, 16'h00a1, 1'b0);
    add_push(128, 16'h00a2, 1'b0);
    add_push(128, 16'h00a3, 1'b0);
    add_pop(1'b0);
    add_pop(1'b0);
    for (int i = 0; i < spq_pkg::QUEUE_DEPTH - 2; i++)
      add_push($urandom_range(126, 130), $urandom_range(0, 65535), 1'b0);
    add_push(255, 16'hffff, 1'b0);

    issued = 0;
    while (issued < RANDOM_WORDS) begin
      mode   = $urandom_range(0, 3);
      len    = $urandom_range(20, 80);
      narrow = 1'($urandom_range(0, 1));
      case (mode)
        0: push_pct = 85;
        1: push_pct = 20;
        2: push_pct = 50;
        default: push_pct = 60;
      endcase
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(1, 100) <= push_pct)
          add_push(narrow ? $urandom_range(0, 3) : $urandom_range(0, 255),
                   $urandom_range(0, 65535),
                   k == 0 && (issued == 0 || $urandom_range(0, 7) == 0));
        else
          add_pop(k == 0 && (issued == 0 || $urandom_range(0, 7) == 0));
        issued++;
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    timed_out = 1'b0;
    while (!(pending_words.size() == 0 && !in_valid && awaited_results.size() == 0)) begin
      @(posedge clk);
      if (idle_cycles >= IDLE_LIMIT) begin
        timed_out = 1'b1;
        break;
      end
    end
    if (!timed_out)
      repeat (TAIL_CYCLES) @(posedge clk);

    if (!timed_out && mismatches == 0 && awaited_results.size() == 0)
      $display("sorted_priority_queue: match");
    else
      $display("sorted_priority_queue: mismatch");
    $finish;
  end

endmodule
